### hw/rtl/merge_sort_engine_defines.svh
// ----------------------------------------------------------------------------
// merge sort engine assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef MERGE_SORT_ENGINE_DEFINES_SVH
`define MERGE_SORT_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MSE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("merge sort engine check failed");

// next-cycle implication
`define MSE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("merge sort engine check failed");

`else

`define MSE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MSE_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### hw/rtl/mse_pkg.sv
// ----------------------------------------------------------------------------
// merge sort engine package
// beat types, queue entry type and operation codes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mse_pkg;

    localparam int KEY_W   = 32;
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam logic [1:0] OP_LOAD      = 2'd0;
    localparam logic [1:0] OP_LOAD_LAST = 2'd1;
    localparam logic [1:0] OP_FETCH     = 2'd2;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key_in;
        logic             last_in;
    } item_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_out;
        logic             last_out;
        logic             empty_out;
        logic             overflow_out;
    } result_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
    } qent_t;

    typedef struct packed {
        logic  valid;
        qent_t ent;
    } q_head_t;

    typedef struct packed {
        logic idle;
        logic sorting;
    } back_stat_t;

endpackage

### hw/rtl/mse_front.sv
// ----------------------------------------------------------------------------
// merge sort engine front end
// takes input beats, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mse_front
    import mse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output q_head_t head,
    input  logic    pop
);

    qent_t           q_mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_next;
    logic [Q_CW-1:0] cnt_reg;
    logic [Q_CW-1:0] cnt_next;
    logic            push;
    qent_t           ent;

    assign busy = (cnt_reg == Q_CW'(Q_DEPTH));
    assign push = start && !busy;

    always_comb
    begin
        ent.key = item.key_in;
        if (item.command == CMD_FETCH)
        begin
            ent.op = OP_FETCH;
        end
        else if (item.last_in)
        begin
            ent.op = OP_LOAD_LAST;
        end
        else
        begin
            ent.op = OP_LOAD;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + Q_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + Q_AW'(1);
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + Q_CW'(1);
            2'b01:   cnt_next = cnt_reg - Q_CW'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= ent;
        end
    end

    assign head.valid = (cnt_reg != '0);
    assign head.ent   = q_mem_reg[rd_ptr_reg];

endmodule

### hw/rtl/mse_back.sv
// ----------------------------------------------------------------------------
// merge sort engine back end
// key memories, bottom-up merge sequencer and sorted key readout
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mse_back
    import mse_pkg::*;
#(
    parameter int MAX_KEYS = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_head_t    head,
    output logic       pop,
    output back_stat_t stat,
    output logic       done,
    output result_t    result
);

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int LW = CW + 2;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_MRG   = 3'd3;
    localparam logic [2:0] ST_FETCH = 3'd4;

    logic [KEY_W-1:0] bank0_mem [MAX_KEYS];
    logic [KEY_W-1:0] bank1_mem [MAX_KEYS];
    logic [KEY_W-1:0] rd0a_reg;
    logic [KEY_W-1:0] rd0b_reg;
    logic [KEY_W-1:0] rd1a_reg;
    logic [KEY_W-1:0] rd1b_reg;
    logic [KEY_W-1:0] da;
    logic [KEY_W-1:0] db;

    logic             we;
    logic             wbank;
    logic [AW-1:0]    waddr;
    logic [KEY_W-1:0] wdata;
    logic [AW-1:0]    ra;
    logic [AW-1:0]    rb;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] rp_reg;
    logic [CW-1:0] rp_next;
    logic          ready_reg;
    logic          ready_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic          bank_reg;
    logic          bank_next;
    logic [LW-1:0] width_reg;
    logic [LW-1:0] width_next;
    logic [LW-1:0] lo_reg;
    logic [LW-1:0] lo_next;
    logic [CW-1:0] mid_reg;
    logic [CW-1:0] mid_next;
    logic [CW-1:0] hi_reg;
    logic [CW-1:0] hi_next;
    logic [CW-1:0] a_reg;
    logic [CW-1:0] a_next;
    logic [CW-1:0] b_reg;
    logic [CW-1:0] b_next;
    logic [CW-1:0] o_reg;
    logic [CW-1:0] o_next;
    logic          done_reg;
    logic          done_next;
    result_t       result_reg;
    result_t       result_next;

    logic [CW-1:0] cnt_eff;
    logic [CW-1:0] cnt_load;
    logic          ovf_load;
    logic          load_ok;
    logic [LW-1:0] n_l;
    logic [LW-1:0] mid_full;
    logic [LW-1:0] hi_full;
    logic [LW-1:0] lo_step;
    logic [LW-1:0] width_dbl;
    logic          a_ok;
    logic          b_ok;
    logic          take_a;

    // memories
    always_ff @(posedge clk)
    begin
        if (we && !wbank)
        begin
            bank0_mem[waddr] <= wdata;
        end
        if (we && wbank)
        begin
            bank1_mem[waddr] <= wdata;
        end
        rd0a_reg <= bank0_mem[ra];
        rd0b_reg <= bank0_mem[rb];
        rd1a_reg <= bank1_mem[ra];
        rd1b_reg <= bank1_mem[rb];
    end

    assign da = bank_reg ? rd1a_reg : rd0a_reg;
    assign db = bank_reg ? rd1b_reg : rd0b_reg;

    assign ra = (state_reg == ST_IDLE) ? rp_reg[AW-1:0] : a_reg[AW-1:0];
    assign rb = b_reg[AW-1:0];

    // load bookkeeping, a new set starts after a finished sort
    assign cnt_eff  = ready_reg ? '0 : count_reg;
    assign load_ok  = (cnt_eff < CW'(MAX_KEYS));
    assign cnt_load = load_ok ? cnt_eff + CW'(1) : cnt_eff;
    assign ovf_load = (ready_reg ? 1'b0 : ovf_reg) || !load_ok;

    // run bounds and merge choice
    assign n_l       = LW'(count_reg);
    assign mid_full  = lo_reg + width_reg;
    assign width_dbl = width_reg << 1;
    assign hi_full   = lo_reg + width_dbl;
    assign lo_step   = lo_reg + width_dbl;
    assign a_ok      = (a_reg < mid_reg);
    assign b_ok      = (b_reg < hi_reg);
    assign take_a    = a_ok && (!b_ok || (da < db));

    assign pop = (state_reg == ST_IDLE) && head.valid;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rp_next     = rp_reg;
        ready_next  = ready_reg;
        ovf_next    = ovf_reg;
        bank_next   = bank_reg;
        width_next  = width_reg;
        lo_next     = lo_reg;
        mid_next    = mid_reg;
        hi_next     = hi_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        o_next      = o_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        we          = 1'b0;
        wbank       = 1'b0;
        waddr       = cnt_eff[AW-1:0];
        wdata       = head.ent.key;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    unique case (head.ent.op) inside
                        OP_LOAD, OP_LOAD_LAST:
                        begin
                            we         = load_ok;
                            count_next = cnt_load;
                            ovf_next   = ovf_load;
                            rp_next    = '0;
                            ready_next = 1'b0;
                            if (head.ent.op == OP_LOAD_LAST)
                            begin
                                width_next = LW'(1);
                                lo_next    = '0;
                                bank_next  = 1'b0;
                                if (cnt_load <= CW'(1))
                                begin
                                    ready_next = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_RUN;
                                end
                            end
                        end
                        OP_FETCH:
                        begin
                            if (!ready_reg || (rp_reg >= count_reg))
                            begin
                                result_next.key_out      = '0;
                                result_next.last_out     = 1'b0;
                                result_next.empty_out    = 1'b1;
                                result_next.overflow_out = ovf_reg;
                                done_next                = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_FETCH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                mid_next   = (mid_full < n_l) ? mid_full[CW-1:0] : count_reg;
                hi_next    = (hi_full < n_l) ? hi_full[CW-1:0] : count_reg;
                a_next     = lo_reg[CW-1:0];
                b_next     = (mid_full < n_l) ? mid_full[CW-1:0] : count_reg;
                o_next     = lo_reg[CW-1:0];
                state_next = ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_MRG;
            end
            ST_MRG:
            begin
                we     = 1'b1;
                wbank  = !bank_reg;
                waddr  = o_reg[AW-1:0];
                wdata  = take_a ? da : db;
                o_next = o_reg + CW'(1);
                if (take_a)
                begin
                    a_next = a_reg + CW'(1);
                end
                else
                begin
                    b_next = b_reg + CW'(1);
                end
                if (o_reg + CW'(1) == hi_reg)
                begin
                    // run finished
                    if (lo_step >= n_l)
                    begin
                        // pass finished, roles of the banks swap
                        bank_next  = !bank_reg;
                        width_next = width_dbl;
                        lo_next    = '0;
                        if (width_dbl >= n_l)
                        begin
                            ready_next = 1'b1;
                            rp_next    = '0;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_RUN;
                        end
                    end
                    else
                    begin
                        lo_next    = lo_step;
                        state_next = ST_RUN;
                    end
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_FETCH:
            begin
                result_next.key_out      = da;
                result_next.last_out     = (rp_reg + CW'(1) == count_reg);
                result_next.empty_out    = 1'b0;
                result_next.overflow_out = ovf_reg;
                done_next                = 1'b1;
                rp_next                  = rp_reg + CW'(1);
                state_next               = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            rp_reg    <= '0;
            ready_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            bank_reg  <= 1'b0;
            width_reg <= '0;
            lo_reg    <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            o_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rp_reg    <= rp_next;
            ready_reg <= ready_next;
            ovf_reg   <= ovf_next;
            bank_reg  <= bank_next;
            width_reg <= width_next;
            lo_reg    <= lo_next;
            mid_reg   <= mid_next;
            hi_reg    <= hi_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            o_reg     <= o_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done         = done_reg;
    assign result       = result_reg;
    assign stat.idle    = (state_reg == ST_IDLE);
    assign stat.sorting = (state_reg == ST_RUN) || (state_reg == ST_RD)
                          || (state_reg == ST_MRG);

endmodule

### hw/rtl/merge_sort_engine.sv
// ----------------------------------------------------------------------------
// merge sort engine
// Loads unsigned keys into an on-chip store, sorts them ascending after the
// beat flagged last and returns one sorted key per fetch beat. A beat is taken
// when start is high and busy is low; a two-entry queue sits in front of the
// execution unit, so up to two beats are taken while it works, then busy
// rises. A fetch that returns a key passes through a registered memory read.
// The sort of n keys runs ceil(log2 n) passes through two ping-pong key
// memories; each run starts with a setup step and each key is read, then
// compared and written. Each fetch gives one result, on result for exactly
// one cycle with done high; the receiver cannot stall it. Keys beyond
// MAX_KEYS are dropped and flagged as overflow. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "merge_sort_engine_defines.svh"

module merge_sort_engine
    import mse_pkg::*;
#(
    parameter int MAX_KEYS = 1024
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result
);

    q_head_t    head;
    logic       pop;
    back_stat_t stat;

    mse_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .busy  (busy),
        .head  (head),
        .pop   (pop)
    );

    mse_back #(
        .MAX_KEYS (MAX_KEYS)
    ) u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

    `MSE_ASSERT_IMP(a_pop_has_entry, clk, rst_n, pop, head.valid && stat.idle)
    `MSE_ASSERT_IMP(a_no_pop_sorting, clk, rst_n, stat.sorting, !pop && !done)
    `MSE_ASSERT_NXT(a_full_holds, clk, rst_n, busy && !pop, busy)
    `MSE_ASSERT_IMP(a_empty_zero, clk, rst_n, done && result.empty_out, result.key_out == '0 && !result.last_out)

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// merge sort engine testbench
// Loads sets of unsigned keys, fetches them back and checks every returned
// beat against an in-bench sorter that tracks the set, the read position and
// the overflow flag. Directed sets cover the key extremes, duplicates, empty
// answers and new sets after a sort; random sets follow under three sender
// idling profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import mse_pkg::*;

class sort_checker;
    int unsigned depth;
    bit [31:0] set_keys[$];
    int unsigned fetch_pos;
    bit set_sorted;
    bit set_overflow;
    result_t pending_answers[$];
    int unsigned mismatches;
    int unsigned loads;
    int unsigned fetches;
    int unsigned sets_sorted;
    int unsigned overflow_sets;
    int unsigned largest_set;

    function new(int unsigned max_keys);
        depth = max_keys;
    endfunction

    function void note_item(item_t it);
        result_t ans;
        if (it.command == CMD_LOAD) begin
            loads++;
            // a load after a finished sort opens a fresh set
            if (set_sorted) begin
                set_keys.delete();
                fetch_pos = 0;
                set_overflow = 1'b0;
                set_sorted = 1'b0;
            end
            if (set_keys.size() < depth)
                set_keys.push_back(it.key_in);
            else
                set_overflow = 1'b1;
            if (it.last_in) begin
                set_keys.sort();
                fetch_pos = 0;
                set_sorted = 1'b1;
                sets_sorted++;
                if (set_overflow)
                    overflow_sets++;
                if (set_keys.size() > largest_set)
                    largest_set = set_keys.size();
            end
        end
        else begin
            fetches++;
            ans = '0;
            ans.overflow_out = set_overflow;
            if (!set_sorted || fetch_pos >= set_keys.size())
                ans.empty_out = 1'b1;
            else
            begin
                ans.key_out = set_keys[fetch_pos];
                ans.last_out = (fetch_pos + 1 == set_keys.size());
                fetch_pos++;
            end
            pending_answers.push_back(ans);
        end
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (pending_answers.size() == 0) begin
            $display("%0t: result beat with nothing outstanding, actual %h", $time, got);
            mismatches++;
            return;
        end
        want = pending_answers.pop_front();
        if (got.key_out !== want.key_out) begin
            $display("%0t: key_out expected %h actual %h", $time, want.key_out, got.key_out);
            mismatches++;
        end
        if (got.last_out !== want.last_out) begin
            $display("%0t: last_out expected %b actual %b", $time, want.last_out,
                     got.last_out);
            mismatches++;
        end
        if (got.empty_out !== want.empty_out) begin
            $display("%0t: empty_out expected %b actual %b", $time, want.empty_out,
                     got.empty_out);
            mismatches++;
        end
        if (got.overflow_out !== want.overflow_out) begin
            $display("%0t: overflow_out expected %b actual %b", $time, want.overflow_out,
                     got.overflow_out);
            mismatches++;
        end
    endfunction
endclass

module testbench;

    localparam int MAX_KEYS     = 1024;
    localparam int RANDOM_BEATS = 750;
    localparam int STALL_LIMIT  = 100000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item = '0;
    logic    busy;
    logic    done;
    result_t result;

    sort_checker book;
    int unsigned gap_pct;
    int unsigned beats_sent;
    int unsigned idle_cycles;

    merge_sort_engine #(
        .MAX_KEYS(MAX_KEYS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .item(item),
        .busy(busy),
        .done(done),
        .result(result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic send_beat(input logic cmd, input logic [31:0] key, input logic lst);
        bit taken;
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= '{command: cmd, key_in: key, last_in: lst};
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        book.note_item(item);
        beats_sent++;
    endtask

    task automatic send_fetch();
        send_beat(CMD_FETCH, $urandom, 1'($urandom_range(1)));
    endtask

    function automatic bit [31:0] pick_key();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3: return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    // load n keys, the final one flagged last, then read back none, some, all or past the end
    task automatic load_set(input int unsigned n, input bit noisy, input bit full_read);
        int unsigned reads;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(9) == 0)
                send_fetch();
            send_beat(CMD_LOAD, pick_key(), i == n - 1);
        end
        if (full_read)
            reads = n + 1;
        else if ($urandom_range(9) < 7)
            reads = n + $urandom_range(2);
        else
            reads = $urandom_range(n);
        repeat (reads) send_fetch();
    endtask

    always @(negedge clk)
    begin
        if (rst_n && done)
            book.check_result(result);
    end

    always @(negedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        book = new(MAX_KEYS);
        gap_pct = 37;
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty before any sort, extremes and duplicates, past the end
        send_beat(CMD_FETCH, '1, 1'b1);
        send_beat(CMD_LOAD, 32'hFFFF_FFFF, 1'b0);
        send_beat(CMD_LOAD, 32'h0000_0000, 1'b0);
        send_beat(CMD_LOAD, 32'h8000_0000, 1'b0);
        send_beat(CMD_LOAD, 32'h7FFF_FFFF, 1'b0);
        send_beat(CMD_LOAD, 32'h0000_0000, 1'b0);
        send_beat(CMD_LOAD, 32'h0000_0001, 1'b1);
        repeat (4) send_beat(CMD_FETCH, '0, 1'b0);
        repeat (4) send_beat(CMD_FETCH, '1, 1'b1);
        // single key set straight after a sort
        send_beat(CMD_LOAD, 32'h0000_0005, 1'b1);
        send_beat(CMD_FETCH, '0, 1'b1);
        send_beat(CMD_FETCH, '1, 1'b0);
        // fetch while loading, partial read, then a new set
        send_beat(CMD_LOAD, 32'h0000_0003, 1'b0);
        send_beat(CMD_FETCH, $urandom, 1'b1);
        send_beat(CMD_LOAD, 32'h0000_0002, 1'b1);
        send_beat(CMD_FETCH, $urandom, 1'b0);
        send_beat(CMD_LOAD, 32'h0000_0009, 1'b1);
        send_beat(CMD_FETCH, $urandom, 1'b0);
        send_beat(CMD_FETCH, $urandom, 1'b1);

        // random sets under the three idling profiles
        while (beats_sent < RANDOM_BEATS)
        begin
            if (beats_sent < 300)
                gap_pct = 37;
            else if (beats_sent < 550)
                gap_pct = 56;
            else
                gap_pct = 0;
            if ($urandom_range(9) == 0)
                load_set($urandom_range(33, 100), 1'b1, 1'b0);
            else
                load_set($urandom_range(1, 16), 1'b1, 1'b0);
        end

        start <= 1'b0;
        while (book.pending_answers.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("run covered %0d beats: %0d loads and %0d fetches", beats_sent,
                 book.loads, book.fetches);
        $display("%0d sets sorted, largest %0d keys, %0d of them truncated",
                 book.sets_sorted, book.largest_set, book.overflow_sets);
        if (book.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
